// File: rtl/rhc_pkg.sv
// shared types and constants for the rgb/hsl converter
`timescale 1ns / 1ps
package rhc_pkg;

    localparam int NUM_W  = 29;
    localparam int DEN_W  = 21;
    localparam int QUO_W  = 15;
    localparam int LANES  = 3;

    localparam logic OP_TO_HSL = 1'b0;
    localparam logic OP_TO_RGB = 1'b1;

    localparam int HUE_SECTOR = 3840;
    localparam int HUE_FULL   = 23040;
    localparam int HUE_MAX    = 23039;
    localparam int COMP_MAX   = 255;
    localparam int RGB_DIV    = 2 * COMP_MAX * HUE_SECTOR;

    typedef struct packed {
        logic                             op;
        logic [7:0]                       light;
        logic [LANES-1:0][NUM_W-1:0]      rem;
        logic [LANES-1:0][DEN_W-1:0]      den;
        logic [LANES-1:0][QUO_W-1:0]      quo;
    } t_div;

endpackage

// File: rtl/rhc_front.sv
// input stages: min/max, chroma and sector math, divider operand setup
`timescale 1ns / 1ps
module rhc_front
    import rhc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_vld,
    input  logic        i_op,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic [14:0] i_hue,
    input  logic [7:0]  i_sat,
    input  logic [7:0]  i_light,
    output logic        o_vld,
    output t_div        o_d
);

    typedef struct packed {
        logic                        op;
        logic [7:0]                  light;
        logic [LANES-1:0][NUM_W-1:0] num;
        logic [LANES-1:0][DEN_W-1:0] den;
        logic [15:0]                 c2;
        logic [11:0]                 xf;
        logic [2:0]                  sec;
        logic [7:0]                  l;
    } t_pre;

    t_pre r_a, n_a;
    logic r_a_vld, r_b_vld;
    t_div r_b, n_b;

    logic [7:0]  mx, mn, c;
    logic [8:0]  sum, den_s;
    logic [22:0] num_h;
    logic [8:0]  l2;
    logic [7:0]  l_dev;
    logic [2:0]  sec;
    logic [14:0] base, hmod;

    always_comb begin
        mx = i_red;
        mn = i_red;
        if (i_green > mx) mx = i_green;
        if (i_blue > mx) mx = i_blue;
        if (i_green < mn) mn = i_green;
        if (i_blue < mn) mn = i_blue;
        c   = mx - mn;
        sum = {1'b0, mx} + {1'b0, mn};
        den_s = (sum > 9'd255) ? 9'd510 - sum : sum;
        if (mx == i_red) begin
            if (i_green >= i_blue) num_h = 23'(12'd3840) * 23'(i_green - i_blue);
            else num_h = 23'(15'd23040) * 23'(c) - 23'(12'd3840) * 23'(i_blue - i_green);
        end else if (mx == i_green) begin
            if (i_blue >= i_red) num_h = 23'(13'd7680) * 23'(c) + 23'(12'd3840) * 23'(i_blue - i_red);
            else num_h = 23'(13'd7680) * 23'(c) - 23'(12'd3840) * 23'(i_red - i_blue);
        end else begin
            if (i_red >= i_green) num_h = 23'(14'd15360) * 23'(c) + 23'(12'd3840) * 23'(i_red - i_green);
            else num_h = 23'(14'd15360) * 23'(c) - 23'(12'd3840) * 23'(i_green - i_red);
        end

        l2    = {i_light, 1'b0};
        l_dev = (l2 >= 9'd255) ? 8'(l2 - 9'd255) : 8'(9'd255 - l2);
        sec  = 3'(i_hue >= 15'd3840) + 3'(i_hue >= 15'd7680) + 3'(i_hue >= 15'd11520)
             + 3'(i_hue >= 15'd15360) + 3'(i_hue >= 15'd19200) + 3'(i_hue >= 15'd23040);
        case (sec)
            3'd0:    base = 15'd0;
            3'd1:    base = 15'd3840;
            3'd2:    base = 15'd7680;
            3'd3:    base = 15'd11520;
            3'd4:    base = 15'd15360;
            3'd5:    base = 15'd19200;
            default: base = 15'd23040;
        endcase
        hmod = i_hue - base;

        n_a       = '0;
        n_a.op    = i_op;
        n_a.light = sum[8:1];
        n_a.den[0] = DEN_W'(1);
        n_a.den[1] = DEN_W'(1);
        n_a.den[2] = DEN_W'(1);
        if (c != 8'd0) begin
            n_a.num[0] = NUM_W'(num_h);
            n_a.den[0] = DEN_W'(c);
            n_a.num[1] = NUM_W'(COMP_MAX) * NUM_W'(c);
            n_a.den[1] = DEN_W'(den_s);
        end
        n_a.c2  = (8'd255 - l_dev) * i_sat;
        n_a.xf  = sec[0] ? 12'(15'd3840 - hmod) : hmod[11:0];
        n_a.sec = sec;
        n_a.l   = i_light;
    end

    logic [NUM_W-1:0] cv, xv, mv;

    always_comb begin
        cv = NUM_W'(r_a.c2) * NUM_W'(13'd7680);
        xv = (NUM_W'(r_a.c2) * NUM_W'(r_a.xf)) << 1;
        mv = NUM_W'(r_a.l) * NUM_W'(RGB_DIV) - NUM_W'(r_a.c2) * NUM_W'(HUE_SECTOR);
        n_b       = '0;
        n_b.op    = r_a.op;
        n_b.light = r_a.light;
        if (r_a.op == OP_TO_HSL) begin
            n_b.rem = r_a.num;
            n_b.den = r_a.den;
        end else begin
            n_b.den[0] = DEN_W'(RGB_DIV);
            n_b.den[1] = DEN_W'(RGB_DIV);
            n_b.den[2] = DEN_W'(RGB_DIV);
            n_b.rem[0] = mv;
            n_b.rem[1] = mv;
            n_b.rem[2] = mv;
            case (r_a.sec)
                3'd0: begin n_b.rem[0] = cv + mv; n_b.rem[1] = xv + mv; end
                3'd1: begin n_b.rem[0] = xv + mv; n_b.rem[1] = cv + mv; end
                3'd2: begin n_b.rem[1] = cv + mv; n_b.rem[2] = xv + mv; end
                3'd3: begin n_b.rem[1] = xv + mv; n_b.rem[2] = cv + mv; end
                3'd4: begin n_b.rem[0] = xv + mv; n_b.rem[2] = cv + mv; end
                3'd5: begin n_b.rem[0] = cv + mv; n_b.rem[2] = xv + mv; end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a <= n_a;
            r_b <= n_b;
        end
    end

    assign o_vld = r_b_vld;
    assign o_d   = r_b;

endmodule

// File: rtl/rhc_div_cell.sv
// one restoring-division cell: settles one quotient bit on every lane
`timescale 1ns / 1ps
module rhc_div_cell
    import rhc_pkg::*;
#(
    parameter int BIT = 0
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_vld,
    input  t_div i_d,
    output logic o_vld,
    output t_div o_d
);

    localparam int CMP_W = NUM_W + QUO_W + DEN_W;

    t_div r_d, n_d;
    logic r_vld;
    logic [CMP_W-1:0] sh;

    always_comb begin
        n_d = i_d;
        sh  = '0;
        for (int k = 0; k < LANES; k++) begin
            sh = CMP_W'(i_d.den[k]) << BIT;
            if (CMP_W'(i_d.rem[k]) >= sh) begin
                n_d.rem[k]      = i_d.rem[k] - NUM_W'(sh);
                n_d.quo[k][BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_vld = r_vld;
    assign o_d   = r_d;

endmodule

// File: rtl/rgb_hsl_color_converter_core.sv
// top level of the rgb/hsl converter: front stages, divider cell row, output register
//
// usage
//   slave stream carries one pixel request per transfer; tuser selects the
//   direction (0 rgb to hsl, 1 hsl to rgb), tdata carries the components
//   master stream returns one result per request in request order
//   the pipe has two front stages, fifteen division cells (one
//   quotient bit each, on three lanes) and the output register
//   throughput is one request per cycle; the whole pipe moves when the
//   output register is empty or being taken
//   when the receiver stalls every stage holds and s_axis_tready drops in the
//   same cycle, so no request is lost and none is repeated
//   reset clears all valid flags; the pipe is empty after reset
//   unused result fields are zero; a grey rgb input gives hue and
//   saturation zero; a hue of 23040 or more gives a grey, with all three
//   rgb components equal
`timescale 1ns / 1ps
module rgb_hsl_color_converter_core
    import rhc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // red, green, blue, hue_in(15), sat, light, pad
    input  logic        s_axis_tuser,  // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata   // red, green, blue, hue_out(15), sat, light, pad
);

    logic en;
    logic [QUO_W:0] w_vld;
    t_div           w_d [QUO_W+1];

    logic        r_out_vld;
    logic        r_out_op;
    logic [55:0] r_out;
    logic [55:0] n_out;

    assign en = !r_out_vld || m_axis_tready;
    assign s_axis_tready = en;

    rhc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (s_axis_tvalid),
        .i_op    (s_axis_tuser),
        .i_red   (s_axis_tdata[7:0]),
        .i_green (s_axis_tdata[15:8]),
        .i_blue  (s_axis_tdata[23:16]),
        .i_hue   (s_axis_tdata[38:24]),
        .i_sat   (s_axis_tdata[46:39]),
        .i_light (s_axis_tdata[54:47]),
        .o_vld   (w_vld[0]),
        .o_d     (w_d[0])
    );

    for (genvar g = 0; g < QUO_W; g++) begin : g_cell
        rhc_div_cell #(.BIT(QUO_W - 1 - g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (w_vld[g]),
            .i_d     (w_d[g]),
            .o_vld   (w_vld[g+1]),
            .o_d     (w_d[g+1])
        );
    end

    function automatic logic [7:0] sat8(input logic [QUO_W-1:0] v);
        sat8 = (v > QUO_W'(COMP_MAX)) ? 8'(COMP_MAX) : v[7:0];
    endfunction

    t_div last;
    always_comb begin
        last  = w_d[QUO_W];
        n_out = '0;
        if (last.op == OP_TO_HSL) begin
            n_out[38:24] = (last.quo[0] > QUO_W'(HUE_MAX)) ? 15'(HUE_MAX) : last.quo[0];
            n_out[46:39] = sat8(last.quo[1]);
            n_out[54:47] = last.light;
        end else begin
            n_out[7:0]   = sat8(last.quo[0]);
            n_out[15:8]  = sat8(last.quo[1]);
            n_out[23:16] = sat8(last.quo[2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= w_vld[QUO_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out    <= n_out;
            r_out_op <= last.op;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out;

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out[38:24] <= 15'(HUE_MAX)))
        else $error("hue result out of range");

    a_rgb_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_op == OP_TO_RGB) |-> (r_out[55:24] == 32'd0))
        else $error("hsl fields not zero on rgb result");

    a_hsl_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_op == OP_TO_HSL) |-> (r_out[23:0] == 24'd0))
        else $error("rgb fields not zero on hsl result");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!r_out_vld || m_axis_tready))
        else $error("ready does not follow output slot");

endmodule

// File: bench/rgb_hsl_color_converter_core_test.sv
// self-checking bench for the rgb/hsl converter core
`timescale 1ns / 1ps
module rgb_hsl_color_converter_core_test;
    import rhc_pkg::*;

    typedef struct {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [14:0] hue;
        logic [7:0]  sat;
        logic [7:0]  light;
    } t_pixel;

    int unsigned mismatches = 0;

    task automatic report(input string what, input longint got, input longint want);
        mismatches++;
        $display("mismatch %s: got %0d expected %0d", what, got, want);
    endtask

    function automatic longint clip(input longint v, input longint hi);
        if (v < 0) return 0;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic t_pixel convert(input logic op, input t_pixel p);
        t_pixel o;
        longint r, g, b, mx, mn, c, sum, num, den, h, s, l, d2l, c2, hm, cv, xv, mv;
        longint rv, gv, bv;
        o = '{default: 0};
        if (op == OP_TO_HSL) begin
            r = p.red; g = p.green; b = p.blue;
            mx = r; mn = r;
            if (g > mx) mx = g;
            if (b > mx) mx = b;
            if (g < mn) mn = g;
            if (b < mn) mn = b;
            c = mx - mn;
            sum = mx + mn;
            o.light = 8'(clip(sum / 2, COMP_MAX));
            if (c != 0) begin
                if (mx == r) begin
                    num = HUE_SECTOR * (g - b);
                    if (num < 0) num += HUE_FULL * c;
                end else if (mx == g) begin
                    num = HUE_SECTOR * (b - r) + 2 * HUE_SECTOR * c;
                end else begin
                    num = HUE_SECTOR * (r - g) + 4 * HUE_SECTOR * c;
                end
                o.hue = 15'(clip(num / c, HUE_MAX));
                den = COMP_MAX - (sum > COMP_MAX ? sum - COMP_MAX : COMP_MAX - sum);
                if (den > 0) o.sat = 8'(clip((COMP_MAX * c) / den, COMP_MAX));
            end
        end else begin
            h = p.hue; s = p.sat; l = p.light;
            d2l = 2 * l - COMP_MAX;
            c2 = (COMP_MAX - (d2l < 0 ? -d2l : d2l)) * s;
            hm = h % (2 * HUE_SECTOR) - HUE_SECTOR;
            cv = c2 * 2 * HUE_SECTOR;
            xv = c2 * 2 * (HUE_SECTOR - (hm < 0 ? -hm : hm));
            mv = l * 2 * COMP_MAX * HUE_SECTOR - c2 * HUE_SECTOR;
            rv = 0; gv = 0; bv = 0;
            case (h / HUE_SECTOR)
                0: begin rv = cv; gv = xv; end
                1: begin rv = xv; gv = cv; end
                2: begin gv = cv; bv = xv; end
                3: begin gv = xv; bv = cv; end
                4: begin rv = xv; bv = cv; end
                5: begin rv = cv; bv = xv; end
                default: ;
            endcase
            o.red   = 8'(clip((rv + mv) / RGB_DIV, COMP_MAX));
            o.green = 8'(clip((gv + mv) / RGB_DIV, COMP_MAX));
            o.blue  = 8'(clip((bv + mv) / RGB_DIV, COMP_MAX));
        end
        return o;
    endfunction

    class pixel_scoreboard;
        t_pixel pending[$];
        int unsigned checked = 0;

        function void note_request(input logic op, input t_pixel p);
            pending.push_back(convert(op, p));
        endfunction

        task check_result(input logic [55:0] d);
            t_pixel w;
            checked++;
            if (pending.size() == 0) begin
                report("unexpected result", d, 0);
                return;
            end
            w = pending.pop_front();
            if (d[7:0] != w.red) report("red", d[7:0], w.red);
            if (d[15:8] != w.green) report("green", d[15:8], w.green);
            if (d[23:16] != w.blue) report("blue", d[23:16], w.blue);
            if (d[38:24] != w.hue) report("hue", d[38:24], w.hue);
            if (d[46:39] != w.sat) report("sat", d[46:39], w.sat);
            if (d[54:47] != w.light) report("light", d[54:47], w.light);
            if (d[55] != 1'b0) report("pad", d[55], 0);
        endtask
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;   // red, green, blue, hue_in(15), sat, light, pad
    logic        s_axis_tuser = 0;    // operation
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [55:0] m_axis_tdata;        // red, green, blue, hue_out(15), sat, light, pad

    rgb_hsl_color_converter_core DUT (.*);

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    pixel_scoreboard board = new();
    int send_idle = 0;
    int recv_stall = 0;
    int hold_off = 0;
    longint cycles = 0;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 400000) begin
            $display("timeout");
            $display("FAILED: results differ");
            $finish;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
    end

    // receiver: random stalls plus the long hold-off
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off--;
            m_axis_tready <= 0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall);
        end
    end

    task automatic send_pixel(input logic op, input t_pixel p);
        while (send_idle > 0 && $urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {1'b0, p.light, p.sat, p.hue, p.blue, p.green, p.red};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note_request(op, p);
        @(negedge i_clk);
    endtask

    function automatic t_pixel random_pixel(input logic op);
        t_pixel p;
        p.red = 8'($urandom); p.green = 8'($urandom); p.blue = 8'($urandom);
        p.sat = 8'($urandom); p.light = 8'($urandom);
        case ($urandom_range(9))
            0:       p.hue = 15'($urandom_range(32767, 23040));
            1:       p.hue = 15'(HUE_SECTOR * $urandom_range(5) + $urandom_range(1) * 3839);
            default: p.hue = 15'($urandom_range(HUE_MAX));
        endcase
        if ($urandom_range(15) == 0) begin
            p.green = p.red; p.blue = p.red;
        end
        return p;
    endfunction

    task automatic directed();
        t_pixel p;
        p = '{default: 0};
        send_pixel(OP_TO_HSL, p);
        p = '{red: 255, green: 255, blue: 255, hue: 32767, sat: 255, light: 255};
        send_pixel(OP_TO_HSL, p);
        send_pixel(OP_TO_RGB, p);
        p = '{red: 255, green: 0, blue: 0, hue: 0, sat: 255, light: 128};
        send_pixel(OP_TO_HSL, p);
        send_pixel(OP_TO_RGB, p);
        p = '{red: 255, green: 0, blue: 1, hue: 23039, sat: 255, light: 127};
        send_pixel(OP_TO_HSL, p);
        send_pixel(OP_TO_RGB, p);
        p = '{red: 0, green: 255, blue: 0, hue: 7680, sat: 128, light: 1};
        send_pixel(OP_TO_HSL, p);
        send_pixel(OP_TO_RGB, p);
        p = '{red: 0, green: 0, blue: 255, hue: 23040, sat: 200, light: 100};
        send_pixel(OP_TO_HSL, p);
        send_pixel(OP_TO_RGB, p);
        p = '{red: 77, green: 77, blue: 77, hue: 16384, sat: 0, light: 254};
        send_pixel(OP_TO_HSL, p);
        send_pixel(OP_TO_RGB, p);
        p = '{red: 200, green: 200, blue: 10, hue: 3840, sat: 255, light: 0};
        send_pixel(OP_TO_HSL, p);
        send_pixel(OP_TO_RGB, p);
        p = '{red: 255, green: 255, blue: 254, hue: 19199, sat: 1, light: 255};
        send_pixel(OP_TO_HSL, p);
        send_pixel(OP_TO_RGB, p);
    endtask

    task automatic random_phase(input int n, input int idle, input int stall);
        logic op;
        send_idle = idle;
        recv_stall = stall;
        repeat (n) begin
            op = 1'($urandom_range(1));
            send_pixel(op, random_pixel(op));
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        directed();
        random_phase(250, 0, 0);
        hold_off = 200;
        random_phase(100, 0, 0);
        random_phase(250, 50, 0);
        random_phase(250, 0, 50);
        random_phase(250, 9, 9);
        random_phase(50, 0, 0);
        s_axis_tvalid <= 0;
        send_idle = 0;
        recv_stall = 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("converted %0d pixels both ways, including grey, wrapped and out-of-range hue",
                 board.checked);
        $display("traffic phases: free flow, sender gaps, receiver stalls, both, long hold-off");
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule

// File: sim.f
rtl/rhc_pkg.sv
rtl/rhc_front.sv
rtl/rhc_div_cell.sv
rtl/rgb_hsl_color_converter_core.sv
bench/rgb_hsl_color_converter_core_test.sv
